// ===== rtl/core/adsr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the ADSR envelope generator.
// No dependencies; imported by the datapath, the top level and the testbench.
package adsr_pkg;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_ATTACK  = 3'd1,
        ST_DECAY   = 3'd2,
        ST_SUSTAIN = 3'd3,
        ST_RELEASE = 3'd4
    } t_stage;

    typedef logic [1:0] t_req;

    localparam t_req REQ_TICK     = 2'd0;
    localparam t_req REQ_NOTE_ON  = 2'd1;
    localparam t_req REQ_NOTE_OFF = 2'd2;

endpackage

// ===== rtl/core/adsr_req_if.sv =====
`timescale 1ns / 1ps
// Request channel: tick, note-on or note-off with envelope settings.
// Valid/ready handshake; widths follow FRAC_BITS.
interface adsr_req_if #(
    parameter int FRAC_BITS = 24
);
    logic                 valid;
    logic                 ready;
    logic [1:0]           req_type;
    logic [FRAC_BITS:0]   attack_step;
    logic [FRAC_BITS-1:0] decay_factor;
    logic [FRAC_BITS:0]   hold_level;
    logic [FRAC_BITS-1:0] fade_factor;

    modport source (
        output valid, req_type, attack_step, decay_factor, hold_level, fade_factor,
        input  ready
    );
    modport sink (
        input  valid, req_type, attack_step, decay_factor, hold_level, fade_factor,
        output ready
    );
endinterface

// ===== rtl/core/adsr_res_if.sv =====
`timescale 1ns / 1ps
// Result channel: envelope level and stage after each tick.
// Valid/ready handshake; level width follows FRAC_BITS.
interface adsr_res_if #(
    parameter int FRAC_BITS = 24
);
    logic               valid;
    logic               ready;
    logic [FRAC_BITS:0] level;
    logic [2:0]         stage;

    modport source (
        output valid, level, stage,
        input  ready
    );
    modport sink (
        input  valid, level, stage,
        output ready
    );
endinterface

// ===== rtl/core/adsr_envelope_generator_core.sv =====
`timescale 1ns / 1ps
// One-voice ADSR envelope generator, unsigned Q1.FRAC_BITS levels.
// Depends on adsr_pkg, adsr_req_if, adsr_res_if, adsr_datapath, adsr_skid.
//
// Every request (tick, note-on, note-off) is taken one per clock while the request
// side has space. A tick updates the level with one add or one multiply against the
// running level and presents the new level and stage on the result channel through
// the result register, or the skid entry while the output stalls. Note-on and
// note-off give no result. The result register is backed by one skid entry, so
// requests keep flowing while a result waits; the request side stalls only when
// both are occupied. The decay term (1 - k) * sustain is precomputed in a register.
module adsr_envelope_generator_core import adsr_pkg::*; #(
    parameter int FRAC_BITS = 24
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    adsr_req_if.sink   i_req,
    adsr_res_if.source o_res
);

    logic                 w_acc;
    logic                 w_push;
    logic                 w_space;
    logic [FRAC_BITS:0]   w_level;
    logic [2:0]           w_stage;

    assign i_req.ready = w_space;
    assign w_acc       = i_req.valid && w_space;

    adsr_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_acc          (w_acc),
        .i_req_type     (i_req.req_type),
        .i_attack_step  (i_req.attack_step),
        .i_decay_factor (i_req.decay_factor),
        .i_hold_level   (i_req.hold_level),
        .i_fade_factor  (i_req.fade_factor),
        .o_push         (w_push),
        .o_level        (w_level),
        .o_stage        (w_stage)
    );

    adsr_skid #(
        .FRAC_BITS (FRAC_BITS)
    ) u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_level (w_level),
        .i_stage (w_stage),
        .o_space (w_space),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_level (o_res.level),
        .o_stage (o_res.stage)
    );

endmodule

// ===== rtl/core/adsr_datapath.sv =====
`timescale 1ns / 1ps
// Envelope state, stage sequencing and per-tick level update.
// Depends on adsr_pkg.
module adsr_datapath import adsr_pkg::*; #(
    parameter int FRAC_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_acc,
    input  logic [1:0]           i_req_type,
    input  logic [FRAC_BITS:0]   i_attack_step,
    input  logic [FRAC_BITS-1:0] i_decay_factor,
    input  logic [FRAC_BITS:0]   i_hold_level,
    input  logic [FRAC_BITS-1:0] i_fade_factor,
    output logic                 o_push,
    output logic [FRAC_BITS:0]   o_level,
    output logic [2:0]           o_stage
);

    localparam int LW = FRAC_BITS + 1;
    localparam int CW = FRAC_BITS;
    localparam longint unsigned ONE_L        = 64'd1 << FRAC_BITS;
    localparam longint unsigned DECAY_SNAP_L = (ONE_L + 64'd500) / 64'd1000;
    localparam longint unsigned FADE_SNAP_L  = (ONE_L + 64'd5000) / 64'd10000;
    localparam logic [LW-1:0] ONE_W        = LW'(ONE_L);
    localparam logic [LW:0]   ONE_X        = (LW+1)'(ONE_L);
    localparam logic [LW:0]   DECAY_SNAP_X = (LW+1)'(DECAY_SNAP_L);
    localparam logic [LW-1:0] FADE_SNAP_W  = LW'(FADE_SNAP_L);

    t_stage         r_stage, n_stage;
    logic [LW-1:0]  r_level, n_level;
    logic [LW-1:0]  r_step;
    logic [CW-1:0]  r_decay;
    logic [CW-1:0]  r_fade;
    logic [LW-1:0]  r_hold;
    logic [LW-1:0]  r_hold_term;

    logic           w_tick;
    logic [LW:0]    w_att_sum;
    logic           w_att_full;
    logic [CW+LW-1:0] w_dec_prod;
    logic [LW:0]    w_dec_sum;
    logic           w_dec_snap;
    logic [LW-1:0]  w_dec_lvl;
    logic [CW+LW-1:0] w_rel_prod;
    logic [LW-1:0]  w_rel_lvl;
    logic           w_rel_snap;
    logic [LW-1:0]  w_one_minus;
    logic [2*LW-1:0] w_ht_prod;

    assign w_tick = i_acc && (i_req_type == REQ_TICK);

    assign w_att_sum  = {1'b0, r_level} + {1'b0, r_step};
    assign w_att_full = (w_att_sum >= ONE_X);

    // constant part of the decay glide, (1 - k) * sustain, refreshed every cycle
    assign w_one_minus = ONE_W - {1'b0, r_decay};
    assign w_ht_prod   = w_one_minus * r_hold;

    assign w_dec_prod = r_decay * r_level;
    assign w_dec_sum  = {1'b0, w_dec_prod[CW+LW-1:FRAC_BITS]} + {1'b0, r_hold_term};
    assign w_dec_snap = (w_dec_sum <= ({1'b0, r_hold} + DECAY_SNAP_X));
    assign w_dec_lvl  = (w_dec_sum > ONE_X) ? ONE_W : w_dec_sum[LW-1:0];

    assign w_rel_prod = r_level * r_fade;
    assign w_rel_lvl  = w_rel_prod[CW+LW-1:FRAC_BITS];
    assign w_rel_snap = (w_rel_lvl < FADE_SNAP_W);

    always_comb begin
        n_stage = r_stage;
        if (i_acc) begin
            case (i_req_type)
                REQ_NOTE_ON: begin
                    n_stage = ST_ATTACK;
                end
                REQ_NOTE_OFF: begin
                    if (r_stage != ST_IDLE) begin
                        n_stage = ST_RELEASE;
                    end
                end
                REQ_TICK: begin
                    case (r_stage)
                        ST_ATTACK:  n_stage = w_att_full ? ST_DECAY : ST_ATTACK;
                        ST_DECAY:   n_stage = w_dec_snap ? ST_SUSTAIN : ST_DECAY;
                        ST_SUSTAIN: n_stage = ST_SUSTAIN;
                        ST_RELEASE: n_stage = w_rel_snap ? ST_IDLE : ST_RELEASE;
                        default:    n_stage = ST_IDLE;
                    endcase
                end
                default: begin
                    n_stage = r_stage;
                end
            endcase
        end
    end

    always_comb begin
        n_level = r_level;
        if (w_tick) begin
            case (r_stage)
                ST_ATTACK:  n_level = w_att_full ? ONE_W : w_att_sum[LW-1:0];
                ST_DECAY:   n_level = w_dec_snap ? r_hold : w_dec_lvl;
                ST_SUSTAIN: n_level = r_hold;
                ST_RELEASE: n_level = w_rel_snap ? '0 : w_rel_lvl;
                default:    n_level = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= ST_IDLE;
            r_level <= '0;
            r_step  <= '0;
            r_decay <= '0;
            r_fade  <= '0;
            r_hold  <= '0;
        end else begin
            r_stage <= n_stage;
            r_level <= n_level;
            if (i_acc && (i_req_type == REQ_NOTE_ON)) begin
                r_step  <= (i_attack_step > ONE_W) ? ONE_W : i_attack_step;
                r_decay <= i_decay_factor;
                r_hold  <= (i_hold_level > ONE_W) ? ONE_W : i_hold_level;
                r_fade  <= i_fade_factor;
            end else if (i_acc && (i_req_type == REQ_NOTE_OFF) && (r_stage != ST_IDLE)) begin
                r_fade <= i_fade_factor;
            end
        end
    end

    // decay is reached only after an attack tick, so the lag of this register is fine
    always_ff @(posedge i_clk) begin
        r_hold_term <= w_ht_prod[LW+FRAC_BITS-1:FRAC_BITS];
    end

    assign o_push  = w_tick;
    assign o_level = n_level;
    assign o_stage = n_stage;

    a_level_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= ONE_W)
        else $error("envelope level above full scale");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stage == ST_IDLE) |-> (r_level == '0))
        else $error("nonzero level while idle");

    a_sustain_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stage == ST_SUSTAIN) |-> (r_level == r_hold))
        else $error("sustain level differs from hold register");

    a_note_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && (i_req_type == REQ_NOTE_ON)) |=> (r_stage == ST_ATTACK))
        else $error("note-on did not enter attack");

endmodule

// ===== rtl/core/adsr_skid.sv =====
`timescale 1ns / 1ps
// Output register with one skid entry for the result channel.
// No package dependencies.
module adsr_skid #(
    parameter int FRAC_BITS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [FRAC_BITS:0] i_level,
    input  logic [2:0]         i_stage,
    output logic               o_space,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [FRAC_BITS:0] o_level,
    output logic [2:0]         o_stage
);

    localparam int DW = FRAC_BITS + 4;

    logic          r_o_valid;
    logic [DW-1:0] r_o_data;
    logic          r_sk_valid;
    logic [DW-1:0] r_sk_data;
    logic          w_load;

    assign w_load = !r_o_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid  <= 1'b0;
            r_sk_valid <= 1'b0;
        end else if (w_load) begin
            if (r_sk_valid) begin
                r_o_valid  <= 1'b1;
                r_sk_valid <= 1'b0;
            end else begin
                r_o_valid <= i_push;
            end
        end else if (i_push) begin
            r_sk_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_data <= r_sk_valid ? r_sk_data : {i_level, i_stage};
        end else if (i_push) begin
            r_sk_data <= {i_level, i_stage};
        end
    end

    assign o_space = !r_sk_valid;
    assign o_valid = r_o_valid;
    assign o_level = r_o_data[DW-1:3];
    assign o_stage = r_o_data[2:0];

    a_sk_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_valid |-> r_o_valid)
        else $error("skid entry held with empty output register");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !r_sk_valid)
        else $error("transfer pushed into full skid entry");

    a_sk_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sk_valid) |-> $past(r_o_valid && !i_ready && i_push))
        else $error("skid entry filled without a stalled output");

endmodule

// ===== tb/sv/tb_adsr_envelope_generator_core.sv =====
`timescale 1ns / 1ps
// Self-checking bench for adsr_envelope_generator_core: directed and random
// note-on / note-off / tick traffic against an in-bench envelope predictor.
// Depends on adsr_pkg, adsr_req_if, adsr_res_if and the core RTL.
module tb_adsr_envelope_generator_core import adsr_pkg::*;;

    localparam int FRAC_BITS = 24;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam longint unsigned ONE_Q = 64'd1 << FRAC_BITS;
    localparam longint unsigned DECAY_SNAP = (ONE_Q + 500) / 1000;
    localparam longint unsigned FADE_SNAP = (ONE_Q + 5000) / 10000;
    localparam int unsigned ONE_I = 32'd1 << FRAC_BITS;
    localparam t_req REQ_UNUSED = 2'd3;

    typedef logic [FRAC_BITS:0] t_lvl;
    typedef logic [FRAC_BITS-1:0] t_coef;

    localparam t_lvl LVL_ONE = t_lvl'(ONE_I);
    localparam t_lvl LVL_MAX = '1;
    localparam t_coef COEF_MAX = '1;

    typedef struct packed {
        t_req  kind;
        t_lvl  step;
        t_coef decay;
        t_lvl  hold;
        t_coef fade;
    } t_req_item;

    typedef struct packed {
        t_lvl   level;
        t_stage stage;
    } t_env_out;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic drv_valid = 1'b0;
    logic sink_ready = 1'b0;
    t_req_item drv_item = '0;

    adsr_req_if #(.FRAC_BITS(FRAC_BITS)) req_bus ();
    adsr_res_if #(.FRAC_BITS(FRAC_BITS)) res_bus ();

    assign req_bus.valid        = drv_valid;
    assign req_bus.req_type     = drv_item.kind;
    assign req_bus.attack_step  = drv_item.step;
    assign req_bus.decay_factor = drv_item.decay;
    assign req_bus.hold_level   = drv_item.hold;
    assign req_bus.fade_factor  = drv_item.fade;
    assign res_bus.ready        = sink_ready;

    adsr_envelope_generator_core #(.FRAC_BITS(FRAC_BITS)) i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_bus),
        .o_res   (res_bus)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    t_req_item pending_reqs[$];
    t_env_out  levels_due[$];

    // envelope predictor state
    t_stage      env_stage = ST_IDLE;
    logic [63:0] env_level = '0;
    logic [63:0] env_step = '0;
    logic [63:0] env_decay = '0;
    logic [63:0] env_fade = '0;
    logic [63:0] env_hold = '0;

    int err_count = 0;
    int accepted_total = 0;
    int note_on_count = 0;
    int note_off_count = 0;
    int ticks_checked = 0;
    int stage_hits[5] = '{default: 0};
    int idle_gap = 0;
    int stall_left = 0;
    int hold_off_asked = 0;
    int hold_off_served = 0;
    int quiet_cycles = 0;
    bit calm = 1'b0;

    function automatic logic [63:0] clamp_full(logic [63:0] v);
        return (v > ONE_Q) ? ONE_Q : v;
    endfunction

    function automatic logic [63:0] q_mul(logic [63:0] a, logic [63:0] b);
        return (a * b) >> FRAC_BITS;
    endfunction

    function automatic void apply_request(t_req_item r);
        logic [63:0] lvl;
        accepted_total++;
        case (r.kind)
            REQ_NOTE_ON: begin
                note_on_count++;
                env_step  = clamp_full(64'(r.step));
                env_decay = 64'(r.decay);
                env_hold  = clamp_full(64'(r.hold));
                env_fade  = 64'(r.fade);
                env_stage = ST_ATTACK;
            end
            REQ_NOTE_OFF: begin
                note_off_count++;
                if (env_stage != ST_IDLE) begin
                    env_fade  = 64'(r.fade);
                    env_stage = ST_RELEASE;
                end
            end
            REQ_TICK: begin
                case (env_stage)
                    ST_ATTACK: begin
                        lvl = env_level + env_step;
                        if (lvl >= ONE_Q) begin
                            lvl = ONE_Q;
                            env_stage = ST_DECAY;
                        end
                    end
                    ST_DECAY: begin
                        lvl = q_mul(env_decay, env_level) + q_mul(ONE_Q - env_decay, env_hold);
                        if (lvl <= env_hold + DECAY_SNAP) begin
                            lvl = env_hold;
                            env_stage = ST_SUSTAIN;
                        end
                    end
                    ST_SUSTAIN: lvl = env_hold;
                    ST_RELEASE: begin
                        lvl = q_mul(env_level, env_fade);
                        if (lvl < FADE_SNAP) begin
                            lvl = '0;
                            env_stage = ST_IDLE;
                        end
                    end
                    default: begin
                        lvl = '0;
                        env_stage = ST_IDLE;
                    end
                endcase
                env_level = clamp_full(lvl);
                levels_due.push_back('{level: t_lvl'(env_level), stage: env_stage});
            end
            default: ;
        endcase
    endfunction

    function automatic t_lvl any_lvl();
        logic [31:0] w;
        w = $urandom;
        return w[FRAC_BITS:0];
    endfunction

    function automatic t_coef any_coef();
        logic [31:0] w;
        w = $urandom;
        return w[FRAC_BITS-1:0];
    endfunction

    function automatic t_coef pick_fade();
        if ($urandom_range(0, 4) == 0)
            return any_coef();
        return t_coef'($urandom_range(ONE_I / 10 * 3, ONE_I / 100 * 95));
    endfunction

    task automatic queue_req(t_req kind, t_lvl step, t_coef decay, t_lvl hold, t_coef fade);
        pending_reqs.push_back('{kind: kind, step: step, decay: decay, hold: hold, fade: fade});
    endtask

    task automatic queue_ticks(int n);
        repeat (n) queue_req(REQ_TICK, any_lvl(), any_coef(), any_lvl(), any_coef());
    endtask

    // one note with random shape, usually released, sometimes cut by noise
    task automatic queue_phrase();
        t_lvl  step;
        t_lvl  hold;
        t_coef decay;
        case ($urandom_range(0, 3))
            0: step = t_lvl'(ONE_I / $urandom_range(1, 8));
            1: step = t_lvl'(ONE_I / $urandom_range(8, 60));
            2: step = any_lvl();
            default: step = t_lvl'($urandom_range(0, 4096));
        endcase
        if ($urandom_range(0, 4) == 0)
            decay = any_coef();
        else
            decay = t_coef'($urandom_range(ONE_I / 4, ONE_I - ONE_I / 16));
        if ($urandom_range(0, 5) == 0)
            hold = any_lvl();
        else
            hold = t_lvl'($urandom_range(0, ONE_I));
        queue_req(REQ_NOTE_ON, step, decay, hold, pick_fade());
        queue_ticks($urandom_range(2, 35));
        if ($urandom_range(0, 4) != 0) begin
            queue_req(REQ_NOTE_OFF, any_lvl(), any_coef(), any_lvl(), pick_fade());
            queue_ticks($urandom_range(2, 40));
        end
        if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 3))
                queue_req(t_req'($urandom_range(0, 3)), any_lvl(), any_coef(), any_lvl(),
                          any_coef());
        end
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || drv_valid || levels_due.size() != 0)
            @(negedge clk);
    endtask

    // request driver
    always @(posedge clk) begin : drive_proc
        logic next_valid;
        if (!rst_n) begin
            drv_valid <= 1'b0;
            idle_gap = 0;
        end else begin
            next_valid = drv_valid;
            if (drv_valid && req_bus.ready) begin
                apply_request(drv_item);
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (idle_gap > 0) begin
                    idle_gap--;
                end else if (pending_reqs.size() != 0) begin
                    if (!calm && $urandom_range(0, 9) == 0) begin
                        idle_gap = $urandom_range(0, 5);
                    end else begin
                        drv_item <= pending_reqs.pop_front();
                        next_valid = 1'b1;
                    end
                end
            end
            drv_valid <= next_valid;
        end
    end

    // result monitor and receiver backpressure
    always @(posedge clk) begin : monitor_proc
        t_env_out want;
        logic next_ready;
        if (rst_n && res_bus.valid && sink_ready) begin
            if (res_bus.stage < 5)
                stage_hits[res_bus.stage]++;
            if (levels_due.size() == 0) begin
                $error("unexpected result: level %0d stage %0d", res_bus.level, res_bus.stage);
                err_count++;
            end else begin
                want = levels_due.pop_front();
                ticks_checked++;
                if (res_bus.level !== want.level) begin
                    $error("level: expected %0d, got %0d", want.level, res_bus.level);
                    err_count++;
                end
                if (res_bus.stage !== want.stage) begin
                    $error("stage: expected %0d, got %0d", want.stage, res_bus.stage);
                    err_count++;
                end
            end
        end
        if (hold_off_served != hold_off_asked) begin
            hold_off_served++;
            stall_left = 60;
        end
        if (stall_left > 0) begin
            stall_left--;
            next_ready = 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 5);
            next_ready = 1'b0;
        end else begin
            next_ready = 1'b1;
        end
        sink_ready <= next_ready;
    end

    always @(posedge clk) begin
        if (!rst_n || (drv_valid && req_bus.ready) || (res_bus.valid && sink_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("adsr_envelope_generator_core verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: idle behavior, ignored requests, clamps, coefficient extremes
        queue_ticks(1);
        queue_req(REQ_NOTE_OFF, LVL_MAX, COEF_MAX, LVL_MAX, COEF_MAX);
        queue_ticks(1);
        queue_req(REQ_UNUSED, LVL_MAX, COEF_MAX, LVL_MAX, COEF_MAX);
        queue_ticks(1);
        queue_req(REQ_NOTE_ON, '0, '0, '0, '0);
        queue_ticks(2);
        queue_req(REQ_NOTE_ON, LVL_MAX, COEF_MAX, LVL_MAX, COEF_MAX);
        queue_ticks(3);
        queue_req(REQ_NOTE_OFF, '0, '0, '0, '0);
        queue_ticks(1);
        queue_req(REQ_NOTE_ON, LVL_ONE, '0, LVL_ONE >> 1, COEF_MAX);
        queue_ticks(3);
        queue_req(REQ_NOTE_OFF, '0, '0, '0, COEF_MAX);
        queue_ticks(2);
        queue_req(REQ_NOTE_ON, LVL_ONE >> 2, t_coef'(ONE_I / 2), LVL_ONE >> 2,
                  t_coef'(ONE_I / 2));
        queue_ticks(4);
        wait_drained();

        // receiver holds off while ticks keep coming
        queue_req(REQ_NOTE_ON, LVL_ONE >> 4, t_coef'(ONE_I / 2), LVL_ONE >> 1,
                  t_coef'(ONE_I / 10 * 9));
        queue_ticks(40);
        hold_off_asked++;
        wait_drained();

        while (pending_reqs.size() < 900)
            queue_phrase();
        while (pending_reqs.size() != 0 || drv_valid)
            @(negedge clk);
        calm = 1'b1;
        repeat (4) queue_phrase();
        wait_drained();
        repeat (8) @(negedge clk);

        if (levels_due.size() != 0) begin
            $error("%0d results never arrived", levels_due.size());
            err_count++;
        end
        $display("covered %0d requests: %0d note-ons, %0d note-offs, %0d tick levels checked",
                 accepted_total, note_on_count, note_off_count, ticks_checked);
        $display("ticks per stage idle/attack/decay/sustain/release: %0d/%0d/%0d/%0d/%0d",
                 stage_hits[0], stage_hits[1], stage_hits[2], stage_hits[3], stage_hits[4]);
        if (err_count == 0) begin
            $display("adsr_envelope_generator_core verification clean");
        end else begin
            $display("adsr_envelope_generator_core verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/adsr_pkg.sv
rtl/core/adsr_req_if.sv
rtl/core/adsr_res_if.sv
rtl/core/adsr_datapath.sv
rtl/core/adsr_skid.sv
rtl/core/adsr_envelope_generator_core.sv
tb/sv/tb_adsr_envelope_generator_core.sv
